// File: hw/rtl/video_fetch_memory_map_top_macros.svh
// Assertion macros used by the controller RTL of the video fetch memory map.
`ifndef VIDEO_FETCH_MEMORY_MAP_TOP_MACROS_SVH
`define VIDEO_FETCH_MEMORY_MAP_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define VFMM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define VFMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/vfmm_pkg.sv
// Types, constants and helpers of the video fetch memory map.
package vfmm_pkg;

  localparam int ADDR_BITS  = 16;
  localparam int MEM_DEPTH  = 1 << ADDR_BITS;
  localparam int FONT_DEPTH = 1024;
  localparam int FONT_AW    = $clog2(FONT_DEPTH);

  // Bus operations
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_FETCH = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_M1_LIMIT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_TOP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIRES_I_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIRES_ENABLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FONT_BOARD   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_PROTECT  = 3'd5;
  localparam int CFG_DATA_W = 16;

  // Configuration reset values
  localparam logic [15:0] M1_LIMIT_RST    = 16'h8000;
  localparam logic [15:0] RAM_TOP_RST     = 16'h7fff;
  localparam logic [7:0]  HIRES_I_MIN_RST = 8'd64;

  // Memory map constants
  localparam logic [15:0] RAM_TOP_SPECIAL = 16'hbfff;
  localparam logic [15:0] LOW_32K_MASK    = 16'h7fff;
  localparam logic [15:0] FETCH_FOLD_BASE = 16'hc000;
  localparam logic [5:0]  FONT_WIN_TAG    = 6'b100001;   // 0x8400..0x87ff
  localparam logic [2:0]  SHADOW_TAG      = 3'b001;      // 8192..16383
  localparam logic [7:0]  CHAR_I_LIMIT    = 8'd64;
  localparam logic [7:0]  BLANK_ROW       = 8'hff;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  i_register;
    logic [6:0]  refresh_count;
    logic        refresh_top_bit;
    logic [2:0]  char_row;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic [7:0] shift_value;
    logic       shift_loaded;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIRST,
    ST_SECOND
  } state_t;

  typedef struct packed {
    logic clr_step;   // write one zero into the font store
    logic accept;     // take the input item and start its first access
    logic issue2;     // start the bitmap read
    logic load1;      // result from the first read
    logic load2;      // result from the bitmap read
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic need_second;
  } sts_t;

  // Fold addresses above the RAM top back into real RAM.
  function automatic logic [15:0] mirror(input logic [15:0] a, input logic [15:0] top);
    logic [15:0] m;
    m = a;
    if (a > top) begin
      if (top == RAM_TOP_SPECIAL) begin
        m = a & LOW_32K_MASK;
      end else begin
        m = a & top;
      end
    end
    return m;
  endfunction

endpackage

// File: hw/rtl/vfmm_ram.sv
// Generic simple dual port RAM with registered read.
module vfmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/vfmm_ctrl.sv
// Controller state machine of the video fetch memory map.
`include "video_fetch_memory_map_top_macros.svh"

module vfmm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  vfmm_pkg::sts_t sts,
  output vfmm_pkg::cmd_t cmd
);

  vfmm_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vfmm_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      vfmm_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = vfmm_pkg::ST_IDLE;
        end
      end
      vfmm_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = vfmm_pkg::ST_FIRST;
        end
      end
      vfmm_pkg::ST_FIRST: begin
        priority if (sts.need_second) begin
          cmd.issue2 = 1'b1;
          state_nxt  = vfmm_pkg::ST_SECOND;
        end else if (out_free) begin
          cmd.load1 = 1'b1;
          state_nxt = vfmm_pkg::ST_IDLE;
        end else begin
          state_nxt = vfmm_pkg::ST_FIRST;
        end
      end
      vfmm_pkg::ST_SECOND: begin
        if (out_free) begin
          cmd.load2 = 1'b1;
          state_nxt = vfmm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = vfmm_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load1 || cmd.load2) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign in_stall  = (state_r != vfmm_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  `VFMM_ASSERT_NOW(a_no_overwrite, cmd.load1 || cmd.load2, out_free, "result overwrote a waiting item")
  `VFMM_ASSERT_NOW(a_clear_blocks, state_r == vfmm_pkg::ST_CLEAR, in_stall, "item taken during font clear")
  `VFMM_ASSERT_NEXT(a_accept_first, cmd.accept, state_r == vfmm_pkg::ST_FIRST, "accept did not start access")
  `VFMM_ASSERT_NOW(a_second_order, state_r == vfmm_pkg::ST_SECOND, $past(state_r) == vfmm_pkg::ST_FIRST || $past(state_r) == vfmm_pkg::ST_SECOND, "bitmap read without first read")

endmodule

// File: hw/rtl/vfmm_dp.sv
// Datapath: configuration, main and font memories, fetch decode, result register.
module vfmm_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [vfmm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vfmm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  vfmm_pkg::in_item_t                  in_item,
  output vfmm_pkg::out_item_t                 out_item,
  input  vfmm_pkg::cmd_t                      cmd,
  output vfmm_pkg::sts_t                      sts
);

  // Configuration
  logic [15:0] m1_limit_r, ram_top_r;
  logic [7:0]  hires_i_min_r;
  logic        hires_enable_r, font_board_r, rom_protect_r;
  logic        font_enabled_r;
  logic [vfmm_pkg::FONT_AW-1:0] clr_cnt_r;

  // Item context
  logic [1:0] op_r;
  logic       video_r;
  logic [7:0] ireg_r;
  logic [6:0] rcnt_r;
  logic       rtop_r;
  logic [2:0] row_r;
  logic       inv_r, src_font_r;
  vfmm_pkg::out_item_t out_item_r;

  // Memory ports
  logic        main_we, main_re, font_we, font_re;
  logic [15:0] main_waddr, main_raddr;
  logic [7:0]  main_rdata, font_rdata, font_wdata;
  logic [vfmm_pkg::FONT_AW-1:0] font_waddr, font_raddr;

  // Decode
  logic [15:0] mir_addr, fetch_addr, first_addr, second_addr;
  logic        fetch_video, font_hit, shadow_hit;
  logic        hires_sel, font_sel, char_sel;
  logic [7:0]  d, bmp;
  vfmm_pkg::out_item_t res1, res2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_limit_r     <= vfmm_pkg::M1_LIMIT_RST;
      ram_top_r      <= vfmm_pkg::RAM_TOP_RST;
      hires_i_min_r  <= vfmm_pkg::HIRES_I_MIN_RST;
      hires_enable_r <= 1'b0;
      font_board_r   <= 1'b0;
      rom_protect_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vfmm_pkg::CFG_M1_LIMIT:     m1_limit_r     <= cfg_wdata;
        vfmm_pkg::CFG_RAM_TOP:      ram_top_r      <= cfg_wdata;
        vfmm_pkg::CFG_HIRES_I_MIN:  hires_i_min_r  <= cfg_wdata[7:0];
        vfmm_pkg::CFG_HIRES_ENABLE: hires_enable_r <= cfg_wdata[0];
        vfmm_pkg::CFG_FONT_BOARD:   font_board_r   <= cfg_wdata[0];
        vfmm_pkg::CFG_ROM_PROTECT:  rom_protect_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Accept-cycle address decode
  always_comb begin
    mir_addr    = vfmm_pkg::mirror(in_item.address, ram_top_r);
    fetch_video = (in_item.address >= m1_limit_r);
    fetch_addr  = in_item.address;
    if (fetch_video && in_item.address >= vfmm_pkg::FETCH_FOLD_BASE) begin
      fetch_addr = in_item.address & vfmm_pkg::LOW_32K_MASK;
    end
    first_addr  = (in_item.operation == vfmm_pkg::OP_FETCH) ? fetch_addr : mir_addr;
    font_hit    = font_board_r && (in_item.address[15:10] == vfmm_pkg::FONT_WIN_TAG);
    shadow_hit  = rom_protect_r && (mir_addr[15:13] == vfmm_pkg::SHADOW_TAG);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      font_enabled_r <= 1'b0;
      clr_cnt_r      <= '0;
    end else begin
      if (cmd.accept && in_item.operation == vfmm_pkg::OP_WRITE && font_hit) begin
        font_enabled_r <= 1'b1;
      end
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r    <= in_item.operation;
      video_r <= fetch_video;
      ireg_r  <= in_item.i_register;
      rcnt_r  <= in_item.refresh_count;
      rtop_r  <= in_item.refresh_top_bit;
      row_r   <= in_item.char_row;
    end
    if (cmd.issue2) begin
      inv_r      <= d[7];
      src_font_r <= font_sel;
    end
    if (cmd.load1) begin
      out_item_r <= res1;
    end else if (cmd.load2) begin
      out_item_r <= res2;
    end
  end

  // First-read decode: opcode byte and bitmap source
  always_comb begin
    d         = main_rdata;
    hires_sel = hires_enable_r && (ireg_r >= hires_i_min_r);
    char_sel  = !hires_sel && (ireg_r < vfmm_pkg::CHAR_I_LIMIT);
    font_sel  = char_sel && font_board_r && font_enabled_r;
    sts.need_second = (op_r == vfmm_pkg::OP_FETCH) && video_r && !d[6]
                      && (hires_sel || char_sel);
    sts.clr_last    = &clr_cnt_r;
    if (hires_sel) begin
      second_addr = {ireg_r, rtop_r, rcnt_r - 7'd1};
    end else begin
      second_addr = {ireg_r[7:1], d[5:0], row_r};
    end

    res1 = '0;
    unique case (op_r)
      vfmm_pkg::OP_READ: res1.read_value = d;
      vfmm_pkg::OP_FETCH: begin
        if (!video_r || d[6]) begin
          res1.read_value = d;
        end else begin
          // Neither hi-res nor character fetch: blank row
          res1.shift_value  = d[7] ? ~vfmm_pkg::BLANK_ROW : vfmm_pkg::BLANK_ROW;
          res1.shift_loaded = 1'b1;
        end
      end
      default: res1 = '0;
    endcase

    bmp               = src_font_r ? font_rdata : main_rdata;
    res2.read_value   = '0;
    res2.shift_value  = inv_r ? ~bmp : bmp;
    res2.shift_loaded = 1'b1;
  end

  // Memory port muxes
  always_comb begin
    main_we    = cmd.accept && (in_item.operation == vfmm_pkg::OP_WRITE) && !shadow_hit;
    main_waddr = mir_addr;
    main_re    = (cmd.accept && (in_item.operation == vfmm_pkg::OP_READ ||
                                 in_item.operation == vfmm_pkg::OP_FETCH))
                 || (cmd.issue2 && !font_sel);
    main_raddr = cmd.accept ? first_addr : second_addr;

    font_we    = cmd.clr_step
                 || (cmd.accept && in_item.operation == vfmm_pkg::OP_WRITE && font_hit);
    font_waddr = cmd.clr_step ? clr_cnt_r : in_item.address[vfmm_pkg::FONT_AW-1:0];
    font_wdata = cmd.clr_step ? 8'd0 : in_item.write_data;
    font_re    = cmd.issue2 && font_sel;
    font_raddr = {d[7], d[5:0], row_r};
  end

  vfmm_ram #(
    .WIDTH(8),
    .DEPTH(vfmm_pkg::MEM_DEPTH)
  ) u_main_ram (
    .clk  (clk),
    .we   (main_we),
    .waddr(main_waddr),
    .wdata(in_item.write_data),
    .re   (main_re),
    .raddr(main_raddr),
    .rdata(main_rdata)
  );

  vfmm_ram #(
    .WIDTH(8),
    .DEPTH(vfmm_pkg::FONT_DEPTH)
  ) u_font_ram (
    .clk  (clk),
    .we   (font_we),
    .waddr(font_waddr),
    .wdata(font_wdata),
    .re   (font_re),
    .raddr(font_raddr),
    .rdata(font_rdata)
  );

  assign out_item = out_item_r;

endmodule

// File: hw/rtl/video_fetch_memory_map_top.sv
// Accept leads to ST_FIRST, where a read, write or plain fetch loads its result;
// a video fetch that reads a bitmap byte (main or font RAM) loads it in ST_SECOND.
// Loads wait while a stalled result is held; new items are taken only in ST_IDLE.
// Reset (rst_n low, synchronous): config to defaults, font flag off, then a pass
// over all 1024 font entries zeroes them; no item is taken during that pass.
// Config writes are taken at any time, including during the clearing pass.
module video_fetch_memory_map_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [vfmm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vfmm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input item channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  vfmm_pkg::in_item_t              in_item,
  // result item channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output vfmm_pkg::out_item_t             out_item
);

  // Controller sequences accept, first read, optional bitmap read and the
  // result load; the datapath owns memories, config and the output register.
  vfmm_pkg::cmd_t cmd;
  vfmm_pkg::sts_t sts;

  vfmm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The result register parts the two channels: a new item is taken while
  // the previous result still waits downstream.
  vfmm_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_item  (in_item),
    .out_item (out_item),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule
